/* sv/lge_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lge_pkg: shared types and constants of the life generation engine
// Field widths, operation codes, register indexes and the 3x3 tap table.
// ----------------------------------------------------------------------------
package lge_pkg;

    localparam int GRID_MAX_DEF = 64;

    localparam int OP_W   = 2;
    localparam int RC_W   = 6;
    localparam int GS_W   = 7;
    localparam int NB_W   = 4;
    localparam int LIVE_W = 13;
    localparam int GEN_W  = 32;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    localparam logic [GS_W-1:0]   GRID_SIZE_RST = 7'd64;
    localparam logic [LIVE_W-1:0] LIVE_SAT      = 13'd8191;

    // rule B3/S23
    localparam logic [NB_W-1:0] SURVIVE_LO = 4'd2;
    localparam logic [NB_W-1:0] BIRTH_CNT  = 4'd3;

    // register indexes on the configuration channel
    localparam logic REG_GRID_SIZE = 1'b0;
    localparam logic REG_WRAP_MODE = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // taps 0..8 walk the 3x3 window row by row, tap 4 is the cell itself
    localparam logic [3:0] TAP_CENTER = 4'd4;
    localparam logic [3:0] TAP_NONE   = 4'd9;

    // returns {row select, column select}: 0 minus one, 1 same, 2 plus one
    function automatic logic [3:0] tap_offset(input logic [3:0] tap);
        logic [3:0] sel;
        case (tap)
            4'd0:    sel = {2'd0, 2'd0};
            4'd1:    sel = {2'd0, 2'd1};
            4'd2:    sel = {2'd0, 2'd2};
            4'd3:    sel = {2'd1, 2'd0};
            4'd4:    sel = {2'd1, 2'd1};
            4'd5:    sel = {2'd1, 2'd2};
            4'd6:    sel = {2'd2, 2'd0};
            4'd7:    sel = {2'd2, 2'd1};
            4'd8:    sel = {2'd2, 2'd2};
            default: sel = {2'd1, 2'd1};
        endcase
        return sel;
    endfunction

endpackage
`default_nettype wire

/* sv/life_generation_engine_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_engine_core: Life (B3/S23) board engine
// Cell write and read, board clear, and generation step over an n by n board.
// ----------------------------------------------------------------------------
// One transaction at a time. The result of each is offered in the same
// cycle as the input becomes ready again. In a step, the shared two-port
// board read and a 4-bit adder gather the 3x3 window of each cell in turn,
// and a copy pass then writes the new board back cell by cell. A clear
// sweeps every entry of the board memory, 4^ceil(log2(GRID_MAX)) entries
// (4096 at the default). After reset a clearing pass runs over every entry
// of the board and the neighbor count memory; no item is taken meanwhile,
// configuration writes are. Writing grid_size while idle starts a sweep
// over every entry that clears every cell and count outside the new area.
// Results carry the live count and generation as they stand once the item
// has finished.
module life_generation_engine_core
    import lge_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input: op[1:0], row[7:2], col[13:8], cell_value[14], zero pad
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // result: cell_alive[0], neighbor_count[4:1], living_count[17:5],
    // generation[49:18], zero pad
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [GS_W-1:0]      cfg_data
);

    localparam int IW    = $clog2(GRID_MAX);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = IW + 1;
    localparam int CW    = IW + 8;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_SWEEP, S_STEP, S_COPY, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SW_RESET, SW_CLEAR, SW_TRIM
    } sweep_t;

    state_t            state_reg;
    sweep_t            sweep_mode_reg;
    logic [GS_W-1:0]   grid_size_reg;
    logic              wrap_reg;
    logic [GEN_W-1:0]  gen_reg;
    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] live_acc_reg;
    logic [IW-1:0]     r_reg;
    logic [IW-1:0]     c_reg;
    logic [2:0]        k_reg;
    logic [NB_W-1:0]   cnt_reg;
    logic              self_reg;
    logic              va_reg;
    logic              vb_reg;
    logic              ctr_reg;
    logic [AW-1:0]     idx_reg;
    logic              copy_wv_reg;
    logic              copy_done_reg;
    logic [AW-1:0]     copy_waddr_reg;
    logic              res_inside_reg;
    logic              res_alive_reg;
    logic [NB_W-1:0]   res_nb_reg;
    logic              m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // memory ports
    logic              board_we;
    logic [AW-1:0]     board_waddr;
    logic              board_wdata;
    logic [AW-1:0]     board_ra;
    logic [AW-1:0]     board_rb;
    logic              board_da;
    logic              board_db;
    logic              next_we;
    logic              next_wdata;
    logic [AW-1:0]     next_ra;
    logic              next_da;
    logic              cnt_we;
    logic [AW-1:0]     cnt_waddr;
    logic [NB_W-1:0]   cnt_wdata;
    logic [AW-1:0]     cnt_ra;
    logic [NB_W-1:0]   cnt_da;

    // active side length, clamped to 1..GRID_MAX
    logic [CW-1:0] gs_w;
    logic [CW-1:0] side_w;
    logic [NW-1:0] side;
    logic [IW-1:0] n_m1;

    assign gs_w   = CW'(grid_size_reg);
    assign side_w = (gs_w == '0) ? CW'(1) :
                    (gs_w > CW'(GRID_MAX)) ? CW'(GRID_MAX) : gs_w;
    assign side   = side_w[NW-1:0];
    assign n_m1   = IW'(side - NW'(1));

    // input fields
    op_t           s_op;
    logic [CW-1:0] s_row_w;
    logic [CW-1:0] s_col_w;
    logic          s_val;
    logic          in_inside;
    logic [AW-1:0] in_addr;
    logic          in_acc;
    logic          cfg_acc;

    assign s_op      = op_t'(s_tdata[1:0]);
    assign s_row_w   = CW'(s_tdata[7:2]);
    assign s_col_w   = CW'(s_tdata[13:8]);
    assign s_val     = s_tdata[14];
    assign in_inside = (s_row_w < side_w) && (s_col_w < side_w);
    assign in_addr   = {s_row_w[IW-1:0], s_col_w[IW-1:0]};
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = ((state_reg == S_IDLE) && !s_tvalid) ||
                       ((state_reg == S_SWEEP) && (sweep_mode_reg == SW_RESET));

    // neighbor coordinates of the current cell, edge handling per mode
    logic [IW-1:0] rm, rp, cm, cp;
    logic          rm_ok, rp_ok, cm_ok, cp_ok;

    assign rm    = (r_reg == '0) ? n_m1 : r_reg - IW'(1);
    assign rp    = (r_reg == n_m1) ? '0 : r_reg + IW'(1);
    assign cm    = (c_reg == '0) ? n_m1 : c_reg - IW'(1);
    assign cp    = (c_reg == n_m1) ? '0 : c_reg + IW'(1);
    assign rm_ok = (r_reg != '0) || wrap_reg;
    assign rp_ok = (r_reg != n_m1) || wrap_reg;
    assign cm_ok = (c_reg != '0) || wrap_reg;
    assign cp_ok = (c_reg != n_m1) || wrap_reg;

    function automatic logic [IW:0] pick(input logic [1:0] s,
                                         input logic [IW-1:0] lo,
                                         input logic [IW-1:0] mid,
                                         input logic [IW-1:0] hi,
                                         input logic lo_ok,
                                         input logic hi_ok);
        logic [IW:0] res;
        case (s)
            2'd0:    res = {lo_ok, lo};
            2'd2:    res = {hi_ok, hi};
            default: res = {1'b1, mid};
        endcase
        return res;
    endfunction

    logic [3:0]  tap_a, tap_b;
    logic [3:0]  sel_a, sel_b;
    logic [IW:0] ra_row, ra_col, rb_row, rb_col;
    logic        ok_a, ok_b;

    assign tap_a  = {k_reg, 1'b0};
    assign tap_b  = tap_a + 4'd1;
    assign sel_a  = tap_offset(tap_a);
    assign sel_b  = tap_offset(tap_b);
    assign ra_row = pick(sel_a[3:2], rm, r_reg, rp, rm_ok, rp_ok);
    assign ra_col = pick(sel_a[1:0], cm, c_reg, cp, cm_ok, cp_ok);
    assign rb_row = pick(sel_b[3:2], rm, r_reg, rp, rm_ok, rp_ok);
    assign rb_col = pick(sel_b[1:0], cm, c_reg, cp, cm_ok, cp_ok);
    assign ok_a   = ra_row[IW] && ra_col[IW] && (tap_a != TAP_CENTER);
    assign ok_b   = rb_row[IW] && rb_col[IW] && (tap_b != TAP_NONE);

    // shared adder and rule
    logic [NB_W-1:0] cnt_sum;
    logic            self_now;
    logic            alive_new;
    logic            last_cell;
    logic [AW-1:0]   cur_addr;

    assign cnt_sum   = cnt_reg + NB_W'(va_reg & board_da) + NB_W'(vb_reg & board_db);
    assign self_now  = ctr_reg ? board_da : self_reg;
    assign alive_new = self_now ? ((cnt_sum == SURVIVE_LO) || (cnt_sum == BIRTH_CNT))
                                : (cnt_sum == BIRTH_CNT);
    assign last_cell = (r_reg == n_m1) && (c_reg == n_m1);
    assign cur_addr  = {r_reg, c_reg};

    // sweep position outside the active area
    logic sweep_out;
    assign sweep_out = (CW'(idx_reg[AW-1:IW]) >= side_w) ||
                       (CW'(idx_reg[IW-1:0]) >= side_w);

    // memory port selection
    always_comb begin
        board_we    = 1'b0;
        board_waddr = in_addr;
        board_wdata = s_val;
        board_ra    = in_addr;
        board_rb    = '0;
        next_we     = 1'b0;
        next_wdata  = alive_new;
        next_ra     = cur_addr;
        cnt_we      = 1'b0;
        cnt_waddr   = cur_addr;
        cnt_wdata   = cnt_sum;
        cnt_ra      = in_addr;
        case (state_reg)
            S_IDLE: begin
                board_we = in_acc && (s_op == OP_WRITE) && in_inside;
            end
            S_STEP: begin
                board_ra = {ra_row[IW-1:0], ra_col[IW-1:0]};
                board_rb = {rb_row[IW-1:0], rb_col[IW-1:0]};
                next_we  = (k_reg == 3'd5);
                cnt_we   = (k_reg == 3'd5);
            end
            S_SWEEP: begin
                board_waddr = idx_reg;
                board_wdata = 1'b0;
                board_we    = (sweep_mode_reg != SW_TRIM) || sweep_out;
                cnt_waddr   = idx_reg;
                cnt_wdata   = '0;
                cnt_we      = (sweep_mode_reg == SW_RESET) ||
                              ((sweep_mode_reg == SW_TRIM) && sweep_out);
            end
            S_COPY: begin
                board_we    = copy_wv_reg;
                board_waddr = copy_waddr_reg;
                board_wdata = next_da;
            end
            default: begin
            end
        endcase
    end

    lge_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_board (
        .aclk      (aclk),
        .wr_en     (board_we),
        .wr_addr   (board_waddr),
        .wr_data   (board_wdata),
        .rd_addr_a (board_ra),
        .rd_data_a (board_da),
        .rd_addr_b (board_rb),
        .rd_data_b (board_db)
    );

    lge_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_next_board (
        .aclk      (aclk),
        .wr_en     (next_we),
        .wr_addr   (cur_addr),
        .wr_data   (next_wdata),
        .rd_addr_a (next_ra),
        .rd_data_a (next_da),
        .rd_addr_b ('0),
        .rd_data_b ()
    );

    lge_ram #(.WIDTH(NB_W), .DEPTH(DEPTH)) u_counts (
        .aclk      (aclk),
        .wr_en     (cnt_we),
        .wr_addr   (cnt_waddr),
        .wr_data   (cnt_wdata),
        .rd_addr_a (cnt_ra),
        .rd_data_a (cnt_da),
        .rd_addr_b ('0),
        .rd_data_b ()
    );

    // sequencer, counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP;
            sweep_mode_reg <= SW_RESET;
            idx_reg        <= '0;
            grid_size_reg  <= GRID_SIZE_RST;
            wrap_reg       <= 1'b0;
            gen_reg        <= '0;
            live_reg       <= '0;
            live_acc_reg   <= '0;
            k_reg          <= '0;
            cnt_reg        <= '0;
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            ctr_reg        <= 1'b0;
            copy_wv_reg    <= 1'b0;
            copy_done_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            // configuration write
            if (cfg_acc) begin
                if (cfg_index == REG_GRID_SIZE) begin
                    grid_size_reg <= cfg_data;
                    if (state_reg == S_IDLE) begin
                        state_reg      <= S_SWEEP;
                        sweep_mode_reg <= SW_TRIM;
                        idx_reg        <= '0;
                    end
                end else begin
                    wrap_reg <= cfg_data[0];
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        res_alive_reg  <= 1'b0;
                        res_nb_reg     <= '0;
                        res_inside_reg <= in_inside;
                        case (s_op)
                            OP_WRITE: state_reg <= S_DONE;
                            OP_READ:  state_reg <= S_READ;
                            OP_STEP: begin
                                state_reg    <= S_STEP;
                                r_reg        <= '0;
                                c_reg        <= '0;
                                k_reg        <= '0;
                                cnt_reg      <= '0;
                                live_acc_reg <= '0;
                            end
                            default: begin
                                state_reg      <= S_SWEEP;
                                sweep_mode_reg <= SW_CLEAR;
                                idx_reg        <= '0;
                                gen_reg        <= '0;
                                live_reg       <= '0;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    res_alive_reg <= res_inside_reg & board_da;
                    res_nb_reg    <= res_inside_reg ? cnt_da : '0;
                    state_reg     <= S_DONE;
                end
                S_SWEEP: begin
                    idx_reg <= idx_reg + AW'(1);
                    if (idx_reg == '1) begin
                        state_reg <= (sweep_mode_reg == SW_CLEAR) ? S_DONE : S_IDLE;
                    end
                end
                S_STEP: begin
                    // issue two window reads per cycle, add what came back
                    va_reg  <= (k_reg != 3'd5) && ok_a;
                    vb_reg  <= (k_reg != 3'd5) && ok_b;
                    ctr_reg <= (k_reg != 3'd5) && (tap_a == TAP_CENTER);
                    if (k_reg == 3'd5) begin
                        k_reg   <= '0;
                        cnt_reg <= '0;
                        if (alive_new && (live_acc_reg != LIVE_SAT)) begin
                            live_acc_reg <= live_acc_reg + LIVE_W'(1);
                        end
                        if (last_cell) begin
                            state_reg     <= S_COPY;
                            r_reg         <= '0;
                            c_reg         <= '0;
                            copy_wv_reg   <= 1'b0;
                            copy_done_reg <= 1'b0;
                        end else if (c_reg == n_m1) begin
                            c_reg <= '0;
                            r_reg <= r_reg + IW'(1);
                        end else begin
                            c_reg <= c_reg + IW'(1);
                        end
                    end else begin
                        k_reg <= k_reg + 3'd1;
                        if (k_reg != 3'd0) begin
                            cnt_reg  <= cnt_sum;
                            self_reg <= self_now;
                        end
                    end
                end
                S_COPY: begin
                    // read next board, write board in the following cycle
                    copy_wv_reg    <= !copy_done_reg;
                    copy_waddr_reg <= cur_addr;
                    if (!copy_done_reg) begin
                        if (c_reg == n_m1) begin
                            c_reg <= '0;
                            r_reg <= r_reg + IW'(1);
                        end else begin
                            c_reg <= c_reg + IW'(1);
                        end
                        copy_done_reg <= last_cell;
                    end else if (!copy_wv_reg) begin
                        live_reg  <= live_acc_reg;
                        gen_reg   <= gen_reg + GEN_W'(1);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, gen_reg, live_reg, res_nb_reg,
                                        res_alive_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP) |-> (k_reg <= 3'd5))
        else $error("window sequencer out of range");

    a_copy_in_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        copy_wv_reg |-> (state_reg == S_COPY))
        else $error("board copy write outside copy phase");

    a_one_door: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_acc && cfg_acc))
        else $error("item and configuration taken together");

    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SWEEP) && (sweep_mode_reg == SW_CLEAR)) |->
        ((gen_reg == '0) && (live_reg == '0)))
        else $error("counters not zero during clear");

endmodule
`default_nettype wire

/* sv/lge_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lge_ram: generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lge_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read ports
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for life_generation_engine_core
// Drives cell writes, reads, clears and generation steps over several board
// sizes and both edge modes, predicts each result with a local board model,
// and compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import lge_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = 1'b0;
    logic [GS_W-1:0]      cfg_data = '0;

    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [LIVE_W-1:0] live;
        logic [NB_W-1:0]   nbr;
        logic              alive;
    } life_result_t;

    // local board model
    logic             cell_q [64][64];
    logic [NB_W-1:0]  nbr_q [64][64];
    logic [GEN_W-1:0] gen_q;
    logic [LIVE_W-1:0] live_q;
    logic [GS_W-1:0]  size_q;
    logic             wrap_q;

    life_result_t pending_results[$];
    int           mismatches;
    int           cycles;
    bit           rx_idle_en;
    bit           tx_idle_en;
    bit           hold_rx;

    life_generation_engine_core DUT (.*);

    always #5 aclk = ~aclk;

    // generous limit on the whole run, stalls included
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 12_000_000) begin
            $display("life_generation_engine_core regression: fail");
            $finish;
        end
    end

    function automatic int board_side();
        int n;
        n = size_q;
        if (n == 0) n = 1;
        if (n > 64) n = 64;
        return n;
    endfunction

    function automatic int count_nbrs(int r, int c, int n);
        int k, rr, cc;
        k = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr == 0 && dc == 0) continue;
                rr = r + dr;
                cc = c + dc;
                if (wrap_q) begin
                    rr = (rr + n) % n;
                    cc = (cc + n) % n;
                end else if (rr < 0 || cc < 0 || rr >= n || cc >= n) continue;
                if (cell_q[rr][cc]) k++;
            end
        return k;
    endfunction

    function automatic void advance_generation();
        logic nxt [64][64];
        int   n, k, live;
        n = board_side();
        live = 0;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                k = count_nbrs(r, c, n);
                nbr_q[r][c] = k[NB_W-1:0];
                nxt[r][c] = cell_q[r][c] ? (k == 2 || k == 3) : (k == 3);
                if (nxt[r][c]) live++;
            end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) cell_q[r][c] = nxt[r][c];
        live_q = (live > 8191) ? LIVE_SAT : live[LIVE_W-1:0];
        gen_q = gen_q + 1;
    endfunction

    function automatic life_result_t predict_item(op_t op, int r, int c, logic v);
        life_result_t res;
        bit in_board;
        in_board = (r < board_side()) && (c < board_side());
        res = '0;
        case (op)
            OP_WRITE: if (in_board) cell_q[r][c] = v;
            OP_READ: if (in_board) begin
                res.alive = cell_q[r][c];
                res.nbr = nbr_q[r][c];
            end
            OP_STEP: advance_generation();
            default: begin
                foreach (cell_q[i, j]) cell_q[i][j] = 1'b0;
                gen_q = '0;
                live_q = '0;
            end
        endcase
        res.live = live_q;
        res.gen = gen_q;
        return res;
    endfunction

    // send one item, predicting its result at acceptance; valid drops at the
    // next idle gap or in drain
    task automatic send_item(op_t op, int r, int c, logic v);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, v, c[RC_W-1:0], r[RC_W-1:0], op};
        do @(posedge aclk); while (!s_tready);
        pending_results = {pending_results, predict_item(op, r, c, v)};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // register write while idle; model follows the write
    task automatic write_reg(logic idx, logic [GS_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_GRID_SIZE) begin
            size_q = val;
            for (int r = 0; r < 64; r++)
                for (int c = 0; c < 64; c++)
                    if (r >= board_side() || c >= board_side()) begin
                        cell_q[r][c] = 1'b0;
                        nbr_q[r][c] = '0;
                    end
        end else wrap_q = val[0];
        repeat (4200) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        life_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[49:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[M_TDATA_W-1:50] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: alive %b/%b nbr %0d/%0d live %0d/%0d gen %0d/%0d",
                                 want.alive, got.alive, want.nbr, got.nbr,
                                 want.live, got.live, want.gen, got.gen);
                end
            end
        end
    end

    // receiver with random stall bursts and one long hold-off
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if (hold_rx) m_tready <= 1'b0;
            else if (idle > 0) begin
                idle--;
                m_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                idle = $urandom_range(1, 15);
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    task automatic glider(int r0, int c0);
        send_item(OP_WRITE, r0, c0 + 1, 1);
        send_item(OP_WRITE, r0 + 1, c0 + 2, 1);
        send_item(OP_WRITE, r0 + 2, c0, 1);
        send_item(OP_WRITE, r0 + 2, c0 + 1, 1);
        send_item(OP_WRITE, r0 + 2, c0 + 2, 1);
    endtask

    task automatic test_directed();
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_WRITE, 63, 63, 1);
        send_item(OP_WRITE, 0, 63, 1);
        send_item(OP_WRITE, 63, 0, 1);
        glider(0, 0);
        send_item(OP_STEP, 0, 0, 0);
        send_item(OP_READ, 1, 1, 0);
        send_item(OP_READ, 63, 63, 1);
        send_item(OP_STEP, 63, 63, 1);
        send_item(OP_READ, 2, 1, 0);
        send_item(OP_CLEAR, 5, 5, 1);
        send_item(OP_READ, 2, 1, 0);
    endtask

    task automatic test_sizes();
        write_reg(REG_GRID_SIZE, 7'd5);
        send_item(OP_WRITE, 7, 2, 1);   // outside, ignored
        send_item(OP_READ, 7, 2, 0);
        glider(1, 1);
        send_item(OP_STEP, 0, 0, 0);
        write_reg(REG_WRAP_MODE, 1'b1);
        send_item(OP_STEP, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        write_reg(REG_GRID_SIZE, 7'd1);
        send_item(OP_WRITE, 0, 0, 1);
        send_item(OP_STEP, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        write_reg(REG_GRID_SIZE, 7'd0);
        send_item(OP_STEP, 0, 0, 0);
        write_reg(REG_GRID_SIZE, 7'd2);
        send_item(OP_WRITE, 0, 0, 1);
        send_item(OP_WRITE, 1, 1, 1);
        send_item(OP_STEP, 0, 0, 0);
        send_item(OP_READ, 1, 0, 0);
        write_reg(REG_GRID_SIZE, 7'd127);
        send_item(OP_READ, 63, 63, 0);
    endtask

    task automatic test_random(int items);
        int r, c, n;
        n = board_side();
        for (int i = 0; i < items; i++) begin
            r = (n < 64 && $urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, n - 1);
            c = (n < 64 && $urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, n - 1);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: send_item(OP_WRITE, r, c, $urandom_range(0, 1));
                9, 10, 11, 12, 13, 14:     send_item(OP_READ, r, c, $urandom_range(0, 1));
                15, 16, 17, 18:            send_item(OP_STEP, r, c, $urandom_range(0, 1));
                default:                   send_item(OP_CLEAR, r, c, $urandom_range(0, 1));
            endcase
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge aclk);
                hold_rx = 1'b0;
            end
            test_random(10);
        join
    endtask

    initial begin
        foreach (cell_q[i, j]) begin
            cell_q[i][j] = 1'b0;
            nbr_q[i][j] = '0;
        end
        gen_q = '0;
        live_q = '0;
        size_q = GRID_SIZE_RST;
        wrap_q = 1'b0;
        mismatches = 0;
        cycles = 0;
        hold_rx = 1'b0;
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_sizes();
        write_reg(REG_GRID_SIZE, 7'd8);
        write_reg(REG_WRAP_MODE, 1'b0);
        test_random(30);
        test_backpressure();
        write_reg(REG_WRAP_MODE, 1'b1);
        test_random(30);
        write_reg(REG_GRID_SIZE, 7'd3);
        test_random(20);
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        write_reg(REG_GRID_SIZE, 7'd64);
        write_reg(REG_WRAP_MODE, 1'b0);
        test_random(20);
        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("life_generation_engine_core regression: pass");
        else
            $display("life_generation_engine_core regression: fail");
        $finish;
    end
endmodule

/* files.f */
sv/lge_pkg.sv
sv/lge_ram.sv
sv/life_generation_engine_core.sv
tb/sv/tb.sv
